>>> rtl/core/assert_macros.svh
// Assertion macros shared by the star update RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SFSU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define SFSU_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> rtl/core/sfsu_pkg.sv
// Types and constants of the starfield star update block.
`timescale 1ns / 1ps
package sfsu_pkg;

	localparam int STAR_COUNT   = 256;
	localparam int MEM_AW       = $clog2(STAR_COUNT);
	localparam int ROTATE_STEPS = 2;
	localparam logic [8:0] DEPTH_MAX = 9'd500;

	// job queue between front and back end
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic KIND_PLACE   = 1'b0;
	localparam logic KIND_ADVANCE = 1'b1;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLE_A        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLE_B        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HOLE_C        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STAR_SPEED    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROTATE_SHIFT  = 3'd6;

	typedef struct packed {
		logic               kind;
		logic [7:0]         star_index;
		logic signed [15:0] new_x;
		logic signed [15:0] new_y;
		logic [8:0]         new_depth;
		logic [7:0]         new_color;
		logic signed [15:0] respawn_x;
		logic signed [15:0] respawn_y;
	} item_t;

	typedef struct packed {
		logic        plot_valid;
		logic [14:0] plot_x;
		logic [14:0] plot_y;
		logic [7:0]  plot_color;
		logic        draw;
		logic        off_screen;
		logic        last;
	} result_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [8:0]         z;
		logic [7:0]         color;
	} star_t;

	typedef struct packed {
		logic [14:0] screen_width;
		logic [14:0] screen_height;
		logic [63:0] hole_a;
		logic [63:0] hole_b;
		logic [63:0] hole_c;
		logic [7:0]  star_speed;
		logic [3:0]  rotate_shift;
	} cfg_t;

	// one queued item: old star for the erase, updated star for the draw
	typedef struct packed {
		logic               advance;
		logic [MEM_AW-1:0]  addr;
		star_t              old_star;
		star_t              new_star;
		logic signed [15:0] respawn_x;
		logic signed [15:0] respawn_y;
	} job_t;

	typedef struct packed {
		logic              we;
		logic [MEM_AW-1:0] addr;
		star_t             data;
	} wb_t;

	// stars still owned by the back end, for the front end hazard check
	typedef struct packed {
		logic              cur_v;
		logic [MEM_AW-1:0] cur_addr;
		logic              d1_v;
		logic [MEM_AW-1:0] d1_addr;
		logic              d2_v;
		logic [MEM_AW-1:0] d2_addr;
	} inflight_t;

endpackage

>>> rtl/core/starfield_star_update_top.sv
// Top level of the starfield star update block: config registers and the pipeline.
`timescale 1ns / 1ps
// Star update unit. An item is taken on a clock edge with start high and busy low.
// A place item gives one result, an advance item two (erase, then draw); each
// result shows on result for exactly one cycle with done high and cannot be held
// off. The back end runs one projection per cycle through a two-stage divider; a
// small job queue lets intake run ahead. From start, an item passes through the
// intake stage s0, the star read stage s1, the job queue, the current-job register
// and divider stages d1 and d2 to the result register. An item addressing a star
// that is still in flight waits (busy high) until that star's draw leaves the
// divider.
module starfield_star_update_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  sfsu_pkg::item_t                      item,
	output logic                                 busy,
	output logic                                 done,
	output sfsu_pkg::result_t                    result,
	input  logic                                 cfg_we,
	input  logic [sfsu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [63:0]                          cfg_data
);
	sfsu_pkg::cfg_t       cfg_q;
	logic                 push;
	sfsu_pkg::job_t       push_job;
	logic                 pop;
	sfsu_pkg::job_t       q_head;
	logic                 q_empty;
	logic [sfsu_pkg::QAW:0] q_count;
	logic [sfsu_pkg::MEM_AW-1:0] probe_addr;
	logic                 q_hit;
	sfsu_pkg::inflight_t  inflight;
	sfsu_pkg::wb_t        wb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.screen_width  <= 15'd640;
			cfg_q.screen_height <= 15'd480;
			cfg_q.hole_a        <= '0;
			cfg_q.hole_b        <= '0;
			cfg_q.hole_c        <= '0;
			cfg_q.star_speed    <= 8'd4;
			cfg_q.rotate_shift  <= 4'd6;
		end else if (cfg_we) begin
			case (cfg_index)
				sfsu_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[14:0];
				sfsu_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[14:0];
				sfsu_pkg::REG_HOLE_A:        cfg_q.hole_a        <= cfg_data;
				sfsu_pkg::REG_HOLE_B:        cfg_q.hole_b        <= cfg_data;
				sfsu_pkg::REG_HOLE_C:        cfg_q.hole_c        <= cfg_data;
				sfsu_pkg::REG_STAR_SPEED:    cfg_q.star_speed    <= cfg_data[7:0];
				sfsu_pkg::REG_ROTATE_SHIFT:  cfg_q.rotate_shift  <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	sfsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.busy       (busy),
		.cfg        (cfg_q),
		.q_count    (q_count),
		.q_hit      (q_hit),
		.probe_addr (probe_addr),
		.inflight   (inflight),
		.wb         (wb),
		.push       (push),
		.push_job   (push_job)
	);

	sfsu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head       (q_head),
		.empty      (q_empty),
		.count      (q_count),
		.probe_addr (probe_addr),
		.hit        (q_hit)
	);

	sfsu_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_head   (q_head),
		.q_empty  (q_empty),
		.pop      (pop),
		.inflight (inflight),
		.wb       (wb),
		.done     (done),
		.result   (result)
	);

endmodule

>>> rtl/core/sfsu_queue.sv
// Job queue between the front end and the back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sfsu_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  sfsu_pkg::job_t              push_job,
	input  logic                        pop,
	output sfsu_pkg::job_t              head,
	output logic                        empty,
	output logic [sfsu_pkg::QAW:0]      count,
	input  logic [sfsu_pkg::MEM_AW-1:0] probe_addr,
	output logic                        hit
);
	localparam int QAW = sfsu_pkg::QAW;

	sfsu_pkg::job_t entry_q [sfsu_pkg::QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign head  = entry_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	// any occupied entry addressing the probed star
	always_comb begin
		logic [QAW-1:0] rel;
		hit = 1'b0;
		for (int i = 0; i < sfsu_pkg::QDEPTH; i++) begin
			rel = QAW'(i) - rd_ptr_q;
			if (({1'b0, rel} < count_q) && (entry_q[i].addr == probe_addr)) begin
				hit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	`SFSU_ASSERT(a_no_overflow, push |-> (32'(count_q) < sfsu_pkg::QDEPTH), "job queue overflow")
	`SFSU_ASSERT_NEVER(a_no_underflow, pop && (count_q == '0), "pop from empty job queue")

endmodule

>>> rtl/core/sfsu_front.sv
// Front end: item intake, star table, hazard check and star update.
`timescale 1ns / 1ps
module sfsu_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  sfsu_pkg::item_t             item,
	output logic                        busy,
	input  sfsu_pkg::cfg_t              cfg,
	input  logic [sfsu_pkg::QAW:0]      q_count,
	input  logic                        q_hit,
	output logic [sfsu_pkg::MEM_AW-1:0] probe_addr,
	input  sfsu_pkg::inflight_t         inflight,
	input  sfsu_pkg::wb_t               wb,
	output logic                        push,
	output sfsu_pkg::job_t              push_job
);
	localparam int AW = sfsu_pkg::MEM_AW;

	logic            v_s0;
	sfsu_pkg::item_t item_s0;
	logic            v_s1;
	sfsu_pkg::item_t item_s1;
	sfsu_pkg::star_t star_s1;

	sfsu_pkg::star_t star_mem [sfsu_pkg::STAR_COUNT];

	logic [AW-1:0] addr_s0;
	logic          in_range;
	logic          hazard;
	logic          room;
	logic          go;
	logic          fwd;
	logic          take;

	function automatic sfsu_pkg::star_t rotate(input sfsu_pkg::star_t s, input logic [3:0] sh);
		logic signed [15:0] tx;
		logic signed [15:0] ty;
		sfsu_pkg::star_t    r;
		tx = s.x;
		ty = s.y;
		for (int n = 0; n < sfsu_pkg::ROTATE_STEPS; n++) begin
			tx = tx - (ty >>> sh);
			ty = ty + (tx >>> sh);
		end
		r   = s;
		r.x = tx;
		r.y = ty;
		return r;
	endfunction

	assign addr_s0    = AW'(item_s0.star_index);
	assign probe_addr = addr_s0;
	assign in_range   = (32'(item_s0.star_index) < sfsu_pkg::STAR_COUNT);

	// a star may be in flight only once: its final write lands at the end of d2
	assign hazard = (v_s1 && (AW'(item_s1.star_index) == addr_s0)) || q_hit ||
		(inflight.cur_v && (inflight.cur_addr == addr_s0)) ||
		(inflight.d1_v && (inflight.d1_addr == addr_s0)) ||
		(inflight.d2_v && (inflight.d2_addr == addr_s0));
	assign room = ((32'(q_count) + 32'(v_s1)) < sfsu_pkg::QDEPTH);
	assign fwd  = v_s0 && in_range && !hazard && room;
	assign go   = v_s0 && (!in_range || (!hazard && room));
	assign busy = v_s0 && !go;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			v_s1 <= 1'b0;
		end else begin
			if (take) begin
				v_s0 <= 1'b1;
			end else if (go) begin
				v_s0 <= 1'b0;
			end
			v_s1 <= fwd;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s0 <= item;
		end
		if (fwd) begin
			item_s1 <= item_s0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb.we) begin
			star_mem[wb.addr] <= wb.data;
		end
		if (fwd) begin
			star_s1 <= star_mem[addr_s0];
		end
	end

	always_comb begin
		sfsu_pkg::star_t placed;
		sfsu_pkg::star_t moved;
		placed.x     = item_s1.new_x;
		placed.y     = item_s1.new_y;
		placed.z     = item_s1.new_depth;
		placed.color = item_s1.new_color;
		if (star_s1.z <= {1'b0, cfg.star_speed}) begin
			// depth used up: back to the far plane
			moved       = placed;
			moved.z     = sfsu_pkg::DEPTH_MAX;
			moved.color = star_s1.color;
		end else begin
			moved   = rotate(star_s1, cfg.rotate_shift);
			moved.z = star_s1.z - {1'b0, cfg.star_speed};
		end
		push_job.advance   = (item_s1.kind == sfsu_pkg::KIND_ADVANCE);
		push_job.addr      = AW'(item_s1.star_index);
		push_job.old_star  = star_s1;
		push_job.new_star  = push_job.advance ? moved : placed;
		push_job.respawn_x = item_s1.respawn_x;
		push_job.respawn_y = item_s1.respawn_y;
	end

	assign push = v_s1;

endmodule

>>> rtl/core/sfsu_back.sv
// Back end: erase/draw sequencing, two-stage divider, projection and clipping.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sfsu_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sfsu_pkg::cfg_t      cfg,
	input  sfsu_pkg::job_t      q_head,
	input  logic                q_empty,
	output logic                pop,
	output sfsu_pkg::inflight_t inflight,
	output sfsu_pkg::wb_t       wb,
	output logic                done,
	output sfsu_pkg::result_t   result
);
	localparam int AW = sfsu_pkg::MEM_AW;

	typedef struct packed {
		logic               draw;
		logic               advance;
		logic [AW-1:0]      addr;
		sfsu_pkg::star_t    star;
		logic signed [15:0] respawn_x;
		logic signed [15:0] respawn_y;
		logic               sx;
		logic               sy;
		logic [7:0]         ax_lo;
		logic [7:0]         ay_lo;
		logic [7:0]         qx_hi;
		logic [7:0]         qy_hi;
		logic [8:0]         rx;
		logic [8:0]         ry;
	} d1_t;

	typedef struct packed {
		logic               draw;
		logic               advance;
		logic [AW-1:0]      addr;
		sfsu_pkg::star_t    star;
		logic signed [15:0] respawn_x;
		logic signed [15:0] respawn_y;
		logic               sx;
		logic               sy;
		logic [15:0]        qx;
		logic [15:0]        qy;
	} d2_t;

	sfsu_pkg::job_t    cur_q;
	logic              cur_v_q;
	logic              phase_q;
	logic              v_d1;
	d1_t               job_d1;
	logic              v_d2;
	d2_t               job_d2;
	logic              done_q;
	sfsu_pkg::result_t res_q;

	logic              cur_finish;
	logic              cur_load;
	d1_t               issue;
	d2_t               next_d2;
	sfsu_pkg::result_t res_d;
	logic              off;

	// eight restoring division steps; returns {quotient bits, remainder}
	function automatic logic [16:0] div_step8(input logic [8:0] rem_in,
		input logic [7:0] bits, input logic [8:0] z);
		logic [9:0] r;
		logic [7:0] q;
		r = {1'b0, rem_in};
		q = '0;
		for (int i = 7; i >= 0; i--) begin
			r = {r[8:0], bits[i]};
			if (r >= {1'b0, z}) begin
				r    = r - {1'b0, z};
				q[i] = 1'b1;
			end
		end
		return {q, r[8:0]};
	endfunction

	function automatic logic in_hole(input logic [63:0] h,
		input logic signed [17:0] px, input logic signed [17:0] py);
		logic signed [17:0] x1;
		logic signed [17:0] y1;
		logic signed [17:0] x2;
		logic signed [17:0] y2;
		x1 = {{2{h[15]}}, h[15:0]};
		y1 = {{2{h[31]}}, h[31:16]};
		x2 = {{2{h[47]}}, h[47:32]};
		y2 = {{2{h[63]}}, h[63:48]};
		return (px >= x1) && (px < x2) && (py >= y1) && (py < y2);
	endfunction

	// advance: erase in phase 0, draw in phase 1; place: draw only
	assign cur_finish = cur_v_q && (!cur_q.advance || phase_q);
	assign cur_load   = !cur_v_q || cur_finish;
	assign pop        = cur_load && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			phase_q <= 1'b0;
			v_d1    <= 1'b0;
			v_d2    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (cur_load) begin
				cur_v_q <= !q_empty;
				phase_q <= 1'b0;
			end else if (cur_v_q) begin
				phase_q <= 1'b1;
			end
			v_d1   <= cur_v_q;
			v_d2   <= v_d1;
			done_q <= v_d2;
		end
	end

	always_comb begin
		logic [15:0] ax;
		logic [15:0] ay;
		logic [16:0] dx;
		logic [16:0] dy;
		issue.draw      = !(cur_q.advance && !phase_q);
		issue.advance   = cur_q.advance;
		issue.addr      = cur_q.addr;
		issue.star      = issue.draw ? cur_q.new_star : cur_q.old_star;
		issue.respawn_x = cur_q.respawn_x;
		issue.respawn_y = cur_q.respawn_y;
		issue.sx        = issue.star.x[15];
		issue.sy        = issue.star.y[15];
		// magnitude fits 16 bits unsigned, including the most negative value
		ax = issue.sx ? 16'(-issue.star.x) : issue.star.x;
		ay = issue.sy ? 16'(-issue.star.y) : issue.star.y;
		dx = div_step8(9'd0, ax[15:8], issue.star.z);
		dy = div_step8(9'd0, ay[15:8], issue.star.z);
		issue.qx_hi = dx[16:9];
		issue.rx    = dx[8:0];
		issue.qy_hi = dy[16:9];
		issue.ry    = dy[8:0];
		issue.ax_lo = ax[7:0];
		issue.ay_lo = ay[7:0];
	end

	always_comb begin
		logic [16:0] dx;
		logic [16:0] dy;
		dx = div_step8(job_d1.rx, job_d1.ax_lo, job_d1.star.z);
		dy = div_step8(job_d1.ry, job_d1.ay_lo, job_d1.star.z);
		next_d2.draw      = job_d1.draw;
		next_d2.advance   = job_d1.advance;
		next_d2.addr      = job_d1.addr;
		next_d2.star      = job_d1.star;
		next_d2.respawn_x = job_d1.respawn_x;
		next_d2.respawn_y = job_d1.respawn_y;
		next_d2.sx        = job_d1.sx;
		next_d2.sy        = job_d1.sy;
		next_d2.qx        = {job_d1.qx_hi, dx[16:9]};
		next_d2.qy        = {job_d1.qy_hi, dy[16:9]};
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
		end
		job_d1 <= issue;
		job_d2 <= next_d2;
		res_q  <= res_d;
	end

	// projection, screen test and clipping
	always_comb begin
		logic signed [17:0] hx;
		logic signed [17:0] hy;
		logic signed [17:0] qx;
		logic signed [17:0] qy;
		logic signed [17:0] px;
		logic signed [17:0] py;
		logic signed [17:0] sw;
		logic signed [17:0] sh;
		logic               clip;
		logic               valid;
		hx = {4'b0, cfg.screen_width[14:1]};
		hy = {4'b0, cfg.screen_height[14:1]};
		sw = {3'b0, cfg.screen_width};
		sh = {3'b0, cfg.screen_height};
		qx = {2'b0, job_d2.qx};
		qy = {2'b0, job_d2.qy};
		px = job_d2.sx ? (hx - qx) : (hx + qx);
		py = job_d2.sy ? (hy - qy) : (hy + qy);
		off = (job_d2.star.z == '0) || (px < 0) || (px >= sw) || (py < 0) || (py >= sh);
		clip = in_hole(cfg.hole_a, px, py) || in_hole(cfg.hole_b, px, py) ||
			in_hole(cfg.hole_c, px, py);
		valid = !off && !clip;
		res_d.plot_valid = valid;
		res_d.plot_x     = valid ? px[14:0] : '0;
		res_d.plot_y     = valid ? py[14:0] : '0;
		res_d.plot_color = job_d2.star.color;
		res_d.draw       = job_d2.draw;
		res_d.off_screen = job_d2.draw && off;
		res_d.last       = job_d2.draw;
	end

	// final star write: an advanced star that left the screen respawns far away
	always_comb begin
		wb.we   = v_d2 && job_d2.draw;
		wb.addr = job_d2.addr;
		wb.data = job_d2.star;
		if (job_d2.advance && off) begin
			wb.data.x = job_d2.respawn_x;
			wb.data.y = job_d2.respawn_y;
			wb.data.z = sfsu_pkg::DEPTH_MAX;
		end
	end

	assign inflight.cur_v    = cur_v_q;
	assign inflight.cur_addr = cur_q.addr;
	assign inflight.d1_v     = v_d1;
	assign inflight.d1_addr  = job_d1.addr;
	assign inflight.d2_v     = v_d2;
	assign inflight.d2_addr  = job_d2.addr;

	assign done   = done_q;
	assign result = res_q;

	`SFSU_ASSERT(a_erase_then_draw, done_q && !res_q.draw |=> done_q && res_q.draw, "erase not followed by draw")

endmodule
